// File: hw/rtl/nse_pkg.sv
`timescale 1ns / 1ps
package nse_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CODE_BITS    = 16;
    localparam int CORDIC_STEPS = 18;
    localparam int WORK_BITS    = 30;
    localparam int XY_SHIFT     = 20;
    localparam int ZW_BITS      = WORK_BITS + 2;
    localparam int ROOT_BITS    = WORK_BITS + 1;
    localparam int ANGLE_W      = 40;

    localparam logic [31:0] ANG_ZERO = 32'h0000_0000;
    localparam logic [31:0] ANG_HALF = 32'h8000_0000;
    localparam logic [31:0] ANG_POSQ = 32'h4000_0000;
    localparam logic [31:0] ANG_NEGQ = 32'hC000_0000;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_nse_in;

    typedef struct packed {
        logic [15:0] polar_code;
        logic [15:0] azimuth_code;
    } t_nse_out;

    function automatic logic [31:0] atan_angle(input int idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
            3:  a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
            9:  a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
            12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
            15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
            18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
            21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
            24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
            27: a = 32'h00000005; 28: a = 32'h00000003; 29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/nse_sqrt.sv
`timescale 1ns / 1ps
module nse_sqrt #(
    parameter int N      = nse_pkg::ROOT_BITS,
    parameter int SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2*N-1:0]      i_value,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [N-1:0]        o_root,
    output logic [SIDE_W-1:0]   o_side
);
    import nse_pkg::*;

    logic              r_val  [0:N];
    logic [2*N-1:0]    r_v    [0:N];
    logic [N+1:0]      r_r    [0:N];
    logic [N-1:0]      r_q    [0:N];
    logic [SIDE_W-1:0] r_side [0:N];

    always_comb begin
        r_val[0]  = i_valid;
        r_v[0]    = i_value;
        r_r[0]    = '0;
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [N+1:0] n_r;
        logic [N+1:0] n_t;
        logic         n_ge;
        always_comb begin
            n_r  = {r_r[k][N-1:0], r_v[k][2*N-1 -: 2]};
            n_t  = {r_q[k], 2'b01};
            n_ge = (n_r >= n_t);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k+1] <= 1'b0;
            end else begin
                r_val[k+1] <= r_val[k];
            end
            r_v[k+1]    <= {r_v[k][2*N-3:0], 2'b00};
            r_r[k+1]    <= n_ge ? (n_r - n_t) : n_r;
            r_q[k+1]    <= {r_q[k][N-2:0], n_ge};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_val[N];
    assign o_root  = r_q[N];
    assign o_side  = r_side[N];

endmodule

// File: hw/rtl/nse_cordic.sv
`timescale 1ns / 1ps
module nse_cordic #(
    parameter int W     = nse_pkg::ANGLE_W,
    parameter int STEPS = nse_pkg::CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    output logic                o_valid,
    output logic [31:0]         o_angle
);
    import nse_pkg::*;

    logic                r_val  [0:STEPS];
    logic                r_fix  [0:STEPS];
    logic signed [W-1:0] r_x    [0:STEPS];
    logic signed [W-1:0] r_y    [0:STEPS];
    logic [31:0]         r_acc  [0:STEPS];

    logic                n_fix;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_acc;

    always_comb begin
        n_fix = 1'b0;
        n_x   = i_x;
        n_y   = i_y;
        n_acc = ANG_ZERO;
        if (i_y == '0) begin
            n_fix = 1'b1;
            n_acc = i_x[W-1] ? ANG_HALF : ANG_ZERO;
        end else if (i_x == '0) begin
            n_fix = 1'b1;
            n_acc = i_y[W-1] ? ANG_NEGQ : ANG_POSQ;
        end else if (i_x[W-1]) begin
            n_x   = -i_x;
            n_y   = -i_y;
            n_acc = ANG_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else begin
            r_val[0] <= i_valid;
        end
        r_fix[0] <= n_fix;
        r_x[0]   <= n_x;
        r_y[0]   <= n_y;
        r_acc[0] <= n_acc;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        logic signed [W-1:0] n_dx;
        logic signed [W-1:0] n_dy;
        logic                n_pos;
        always_comb begin
            n_dx  = r_y[i] >>> i;
            n_dy  = r_x[i] >>> i;
            n_pos = !r_y[i][W-1] && (r_y[i] != '0);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[i+1] <= 1'b0;
            end else begin
                r_val[i+1] <= r_val[i];
            end
            r_fix[i+1] <= r_fix[i];
            if (r_fix[i]) begin
                r_x[i+1]   <= r_x[i];
                r_y[i+1]   <= r_y[i];
                r_acc[i+1] <= r_acc[i];
            end else if (n_pos) begin
                r_x[i+1]   <= r_x[i] + n_dx;
                r_y[i+1]   <= r_y[i] - n_dy;
                r_acc[i+1] <= r_acc[i] + atan_angle(i);
            end else begin
                r_x[i+1]   <= r_x[i] - n_dx;
                r_y[i+1]   <= r_y[i] + n_dy;
                r_acc[i+1] <= r_acc[i] - atan_angle(i);
            end
        end
    end

    assign o_valid = r_val[STEPS];
    assign o_angle = r_acc[STEPS];

endmodule

// File: hw/rtl/normal_to_spherical_encode.sv
`timescale 1ns / 1ps
// Channel   Handshake        Payload
// input     start, busy      i_in  (norm_x, norm_y, norm_z)
// result    o_done           o_out (polar_code, azimuth_code)
//
// One beat is accepted every cycle; busy is always low.
// The pipeline is one input stage, 31 square root stages
// and a CORDIC of one setup stage plus one stage per iteration.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall; each result is shown for exactly one cycle.
module normal_to_spherical_encode #(
    parameter int CORDIC_STEPS = nse_pkg::CORDIC_STEPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  nse_pkg::t_nse_in i_in,
    output logic             o_done,
    output nse_pkg::t_nse_out o_out
);
    import nse_pkg::*;

    localparam int N      = ROOT_BITS;
    localparam int SIDE_W = 32 + ZW_BITS;
    localparam int LAT    = 2 + N + CORDIC_STEPS;

    logic signed [15:0]      n_zc;
    logic [14:0]             n_zabs;
    logic [29:0]             n_zsq;
    logic                    r_val;
    logic [28:0]             r_a;
    logic signed [ZW_BITS-1:0] r_zw;
    logic signed [15:0]      r_x;
    logic signed [15:0]      r_y;

    always_comb begin
        n_zc = i_in.norm_z;
        if (i_in.norm_z > 16'sd16384) begin
            n_zc = 16'sd16384;
        end else if (i_in.norm_z < -16'sd16384) begin
            n_zc = -16'sd16384;
        end
        n_zabs = n_zc[15] ? 15'(-n_zc) : n_zc[14:0];
        n_zsq  = 30'(n_zabs) * 30'(n_zabs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 1'b0;
        end else begin
            r_val <= start;
        end
        r_a  <= 29'(30'h1000_0000 - n_zsq);
        r_zw <= ZW_BITS'(n_zc) <<< (WORK_BITS - FRAC_BITS);
        r_x  <= i_in.norm_x;
        r_y  <= i_in.norm_y;
    end

    logic                      s_val;
    logic [N-1:0]              s_root;
    logic [SIDE_W-1:0]         s_side;
    logic signed [ZW_BITS-1:0] s_zw;
    logic signed [15:0]        s_x;
    logic signed [15:0]        s_y;

    nse_sqrt #(.N(N), .SIDE_W(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_val),
        .i_value ({1'b0, r_a, 32'd0}),
        .i_side  ({r_x, r_y, r_zw}),
        .o_valid (s_val),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign s_x  = s_side[SIDE_W-1 -: 16];
    assign s_y  = s_side[SIDE_W-17 -: 16];
    assign s_zw = s_side[ZW_BITS-1:0];

    logic              p_val;
    logic              a_val;
    logic [31:0]       p_ang;
    logic [31:0]       a_ang;

    nse_cordic #(.W(ANGLE_W), .STEPS(CORDIC_STEPS)) u_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_val),
        .i_x     (ANGLE_W'(s_zw)),
        .i_y     (signed'(ANGLE_W'(s_root))),
        .o_valid (p_val),
        .o_angle (p_ang)
    );

    nse_cordic #(.W(ANGLE_W), .STEPS(CORDIC_STEPS)) u_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_val),
        .i_x     (ANGLE_W'(s_x) <<< XY_SHIFT),
        .i_y     (ANGLE_W'(s_y) <<< XY_SHIFT),
        .o_valid (a_val),
        .o_angle (a_ang)
    );

    assign busy               = 1'b0;
    assign o_done             = p_val & a_val;
    assign o_out.polar_code   = p_ang[31-CODE_BITS +: CODE_BITS];
    assign o_out.azimuth_code = {~a_ang[31], a_ang[30 -: CODE_BITS-1]};

    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_val == a_val)
        else $error("angle lanes out of step");
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without accepted beat");
    a_reset_clears: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_done)
        else $error("result right after reset");

endmodule

// File: tb/normal_to_spherical_encode_tb.sv
`timescale 1ns / 1ps
class nse_scoreboard;
    nse_pkg::t_nse_out pending[$];
    int mismatches;
    int checked;
    logic [31:0] atan_rom [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    function logic [31:0] binary_angle(longint vx, longint vy);
        logic [31:0] acc;
        longint px;
        longint py;
        longint step_x;
        longint step_y;
        acc = 32'h0;
        px = vx;
        py = vy;
        if (py == 0) return (px < 0) ? 32'h8000_0000 : 32'h0;
        if (px == 0) return (py > 0) ? 32'h4000_0000 : 32'hC000_0000;
        if (px < 0) begin
            px = -px;
            py = -py;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < nse_pkg::CORDIC_STEPS && i < 32; i++) begin
            step_x = py >>> i;
            step_y = px >>> i;
            if (py > 0) begin
                px += step_x;
                py -= step_y;
                acc += atan_rom[i];
            end else begin
                px -= step_x;
                py += step_y;
                acc -= atan_rom[i];
            end
        end
        return acc;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function nse_pkg::t_nse_out encode_normal(nse_pkg::t_nse_in beat);
        nse_pkg::t_nse_out r;
        longint zc;
        longint zw;
        longint unsigned zsq;
        longint root;
        logic [31:0] pol;
        logic [31:0] azi;
        zc = beat.norm_z;
        if (zc > 16384) zc = 16384;
        if (zc < -16384) zc = -16384;
        zw = zc <<< (nse_pkg::WORK_BITS - nse_pkg::FRAC_BITS);
        zsq = (zw < 0) ? -zw : zw;
        zsq = zsq * zsq;
        root = root_floor((64'h1 << (2 * nse_pkg::WORK_BITS)) - zsq);
        pol = binary_angle(zw, root);
        azi = binary_angle(longint'(beat.norm_x) <<< nse_pkg::XY_SHIFT,
                           longint'(beat.norm_y) <<< nse_pkg::XY_SHIFT);
        r.polar_code = pol[30:15];
        azi = azi + 32'h8000_0000;
        r.azimuth_code = azi[31:16];
        return r;
    endfunction

    function void note_input(nse_pkg::t_nse_in beat);
        pending.push_back(encode_normal(beat));
    endfunction

    function bit near(logic [15:0] a, logic [15:0] e);
        logic [15:0] d;
        d = a - e;
        return d == 16'h0 || d == 16'h1 || d == 16'hFFFF;
    endfunction

    function void check_result(nse_pkg::t_nse_out got);
        nse_pkg::t_nse_out want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (!near(got.polar_code, want.polar_code) ||
            !near(got.azimuth_code, want.azimuth_code)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected polar %h azimuth %h, got polar %h azimuth %h",
                         want.polar_code, want.azimuth_code,
                         got.polar_code, got.azimuth_code);
        end
    endfunction
endclass

module normal_to_spherical_encode_tb;
    localparam int LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    nse_pkg::t_nse_in i_in = '0;
    logic o_done;
    nse_pkg::t_nse_out o_out;
    int cycles = 0;
    nse_scoreboard sb = new();

    normal_to_spherical_encode uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_done(o_done), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_out);
    end

    task automatic send_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        @(negedge i_clk);
        start = 1'b1;
        i_in.norm_x = x;
        i_in.norm_y = y;
        i_in.norm_z = z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(i_in);
    endtask

    task automatic pause_input(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic [15:0] unit_component();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    initial begin
        int wait_cycles;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_normal(16'd0, 16'd0, 16'd16384);
        send_normal(16'd0, 16'd0, -16'sd16384);
        send_normal(16'd16384, 16'd0, 16'd0);
        send_normal(-16'sd16384, 16'd0, 16'd0);
        send_normal(16'd0, 16'd16384, 16'd0);
        send_normal(16'd0, -16'sd16384, 16'd0);
        send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_normal(16'h8000, 16'h8000, 16'h8000);
        send_normal(16'h8000, 16'h0, 16'h7FFF);
        send_normal(16'h7FFF, 16'h0, 16'h8000);
        send_normal(16'h0, 16'h8000, 16'd16385);
        send_normal(16'h0, 16'h7FFF, -16'sd16385);
        send_normal(16'hFFFF, 16'h0001, 16'd1);
        send_normal(16'h0001, 16'hFFFF, 16'hFFFF);
        send_normal(16'd11585, 16'd11585, 16'd0);
        send_normal(-16'sd11585, -16'sd11585, 16'd9000);
        send_normal(16'h8000, 16'h7FFF, 16'd0);
        send_normal(16'h7FFF, 16'h8000, 16'd0);
        send_normal(16'h5555, 16'hAAAA, 16'h5555);
        send_normal(16'hAAAA, 16'h5555, 16'hAAAA);

        for (int i = 0; i < 650; i++) begin
            case ($urandom_range(9))
                0: send_normal(16'($urandom), 16'($urandom), 16'($urandom));
                1: send_normal(16'h0, $urandom_range(1) ? 16'h0 : unit_component(),
                               unit_component());
                2: send_normal(unit_component(), 16'h0, unit_component());
                default: send_normal(unit_component(), unit_component(), unit_component());
            endcase
            if (i < 550 && $urandom_range(3) == 0) pause_input($urandom_range(19, 1));
        end
        @(negedge i_clk);
        start = 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);

        $display("Checked %0d encoded normals: axis, saturated-z, zero-xy and random vectors.",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: normal_to_spherical_encode.f
hw/rtl/nse_pkg.sv
hw/rtl/nse_sqrt.sv
hw/rtl/nse_cordic.sv
hw/rtl/normal_to_spherical_encode.sv
tb/normal_to_spherical_encode_tb.sv
